/* rtl/srs_pkg.sv */
package srs_pkg;

    localparam int unsigned MAX_BLOCKS = 4096;
    localparam int unsigned IDX_W      = 12;
    localparam int unsigned CNT_W      = 13;
    localparam int unsigned BYTES_W    = 16;
    localparam int unsigned DUP_W      = 16;
    localparam int unsigned BURST_W    = 6;
    localparam int unsigned BATCH_W    = 12;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic OP_START = 1'b0;
    localparam logic OP_ACK   = 1'b1;

    localparam logic [2:0] KIND_SEND      = 3'd0;
    localparam logic [2:0] KIND_NEW_ACK   = 3'd1;
    localparam logic [2:0] KIND_DUP_ACK   = 3'd2;
    localparam logic [2:0] KIND_COMPLETE  = 3'd3;
    localparam logic [2:0] KIND_BAD_INDEX = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_BLOCK_BYTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_BURST      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_BURST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_BATCH        = 3'd4;

    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] block_index;
    } srs_in_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [IDX_W-1:0]   pick_index;
        logic [BYTES_W-1:0] block_bytes;
        logic               last;
        logic [CNT_W-1:0]   acked_count;
        logic [DUP_W-1:0]   duplicate_count;
    } srs_out_t;

endpackage

/* rtl/selective_resend_scheduler_core.sv */
// channel   direction  handshake          beat
// s_        in         s_valid / s_ready  srs_in_t  (operation, block_index)
// m_        out        m_valid / m_ready  srs_out_t (kind ... duplicate_count)
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata
//
// Clearing pass after reset: one bitmap entry a cycle, s_ready low.
// Ack beat: bitmap read in ST_ACK_RD, result registered from ST_ACK_CHK; an
// out-of-range index is answered straight from idle. Send pick: the shared scan
// unit reads one bitmap entry a cycle, skipping acked entries, for ST_EMIT.
// A stalled result holds the sequencer; s_ready is high only in idle while the
// result register is empty or its beat is taken that cycle.
module selective_resend_scheduler_core #(
    parameter int unsigned BLOCK_BYTES = 60000
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [srs_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  srs_pkg::srs_in_t                       s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output srs_pkg::srs_out_t                      m_data
);
    import srs_pkg::*;

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_ACK_RD  = 3'd2;
    localparam logic [2:0] ST_ACK_CHK = 3'd3;
    localparam logic [2:0] ST_SCAN    = 3'd4;
    localparam logic [2:0] ST_EMIT    = 3'd5;

    localparam logic [BYTES_W-1:0] FULL_BYTES = BYTES_W'(BLOCK_BYTES);

    logic [CNT_W-1:0]   total_blocks_reg;
    logic [BYTES_W-1:0] last_bytes_reg;
    logic [BURST_W-1:0] start_burst_reg;
    logic [BURST_W-1:0] refill_burst_reg;
    logic [BATCH_W-1:0] ack_batch_reg;

    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   acked_reg, acked_next;
    logic [DUP_W-1:0]   dup_reg, dup_next;
    logic [BATCH_W-1:0] bp_reg, bp_next;
    logic               finished_reg, finished_next;
    logic               chk_vld_reg, chk_vld_next;
    logic               m_valid_reg, m_valid_next;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   cand_reg, cand_next;
    logic [IDX_W-1:0]   chk_reg, chk_next;
    logic [CNT_W-1:0]   steps_reg, steps_next;
    logic [BURST_W-1:0] made_reg, made_next;
    logic [BURST_W-1:0] want_reg, want_next;
    logic [IDX_W-1:0]   pick_reg, pick_next;
    srs_out_t           out_reg, out_next;

    logic               map_mem [MAX_BLOCKS];
    logic               mem_q_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic               mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;

    logic [CNT_W-1:0]   blk_n;
    logic               out_free;
    logic               ready_c;

    function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] c,
                                                  input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] c1;
        c1 = {1'b0, c} + CNT_W'(1);
        return (c1 >= n) ? '0 : c1[IDX_W-1:0];
    endfunction

    function automatic srs_out_t make_item(input logic [2:0]         kind,
                                           input logic [IDX_W-1:0]   idx,
                                           input logic [BYTES_W-1:0] bytes,
                                           input logic               last,
                                           input logic [CNT_W-1:0]   acked,
                                           input logic [DUP_W-1:0]   dup);
        srs_out_t r;
        r.kind            = kind;
        r.pick_index      = idx;
        r.block_bytes     = bytes;
        r.last            = last;
        r.acked_count     = acked;
        r.duplicate_count = dup;
        return r;
    endfunction

    always_comb begin
        if (total_blocks_reg == '0) begin
            blk_n = CNT_W'(1);
        end else if (total_blocks_reg > CNT_W'(MAX_BLOCKS)) begin
            blk_n = CNT_W'(MAX_BLOCKS);
        end else begin
            blk_n = total_blocks_reg;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_blocks_reg <= CNT_W'(1);
            last_bytes_reg   <= '0;
            start_burst_reg  <= BURST_W'(63);
            refill_burst_reg <= BURST_W'(50);
            ack_batch_reg    <= BATCH_W'(50);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TOTAL_BLOCKS:     total_blocks_reg <= cfg_wdata[CNT_W-1:0];
                REG_LAST_BLOCK_BYTES: last_bytes_reg   <= cfg_wdata[BYTES_W-1:0];
                REG_START_BURST:      start_burst_reg  <= cfg_wdata[BURST_W-1:0];
                REG_REFILL_BURST:     refill_burst_reg <= cfg_wdata[BURST_W-1:0];
                REG_ACK_BATCH:        ack_batch_reg    <= cfg_wdata[BATCH_W-1:0];
                default: ;
            endcase
        end
    end

    // ack bitmap
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= map_mem[mem_raddr];
        end
    end

    always_comb begin
        logic [CNT_W-1:0]   acked_inc;
        logic [DUP_W-1:0]   dup_inc;
        logic [BATCH_W-1:0] bp_inc;
        logic               refill_go;
        logic               last_pick;

        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        ptr_next      = ptr_reg;
        acked_next    = acked_reg;
        dup_next      = dup_reg;
        bp_next       = bp_reg;
        finished_next = finished_reg;
        chk_vld_next  = chk_vld_reg;
        idx_next      = idx_reg;
        cand_next     = cand_reg;
        chk_next      = chk_reg;
        steps_next    = steps_reg;
        made_next     = made_reg;
        want_next     = want_reg;
        pick_next     = pick_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = cand_reg;
        ready_c       = 1'b0;

        acked_inc = (acked_reg == '1) ? acked_reg : acked_reg + CNT_W'(1);
        dup_inc   = (dup_reg == '1) ? dup_reg : dup_reg + DUP_W'(1);
        bp_inc    = bp_reg + BATCH_W'(1);
        refill_go = 1'b0;
        last_pick = (BURST_W'(made_reg + BURST_W'(1)) == want_reg);

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(MAX_BLOCKS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ready_c = out_free;
                if (s_valid && out_free) begin
                    if (s_data.operation == OP_START) begin
                        if (!finished_reg) begin
                            want_next    = (start_burst_reg == '0) ? BURST_W'(1)
                                                                   : start_burst_reg;
                            made_next    = '0;
                            cand_next    = step_idx(ptr_reg, blk_n);
                            steps_next   = '0;
                            chk_vld_next = 1'b0;
                            state_next   = ST_SCAN;
                        end
                    end else if ({1'b0, s_data.block_index} >= blk_n) begin
                        out_next     = make_item(KIND_BAD_INDEX, s_data.block_index, '0,
                                                 1'b1, acked_reg, dup_reg);
                        m_valid_next = 1'b1;
                    end else begin
                        idx_next   = s_data.block_index;
                        state_next = ST_ACK_RD;
                    end
                end
            end
            ST_ACK_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = idx_reg;
                state_next = ST_ACK_CHK;
            end
            ST_ACK_CHK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (mem_q_reg) begin
                        dup_next = dup_inc;
                        out_next = make_item(KIND_DUP_ACK, idx_reg, '0, 1'b1,
                                             acked_reg, dup_inc);
                    end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = idx_reg;
                        mem_wdata  = 1'b1;
                        acked_next = acked_inc;
                        if (!finished_reg && acked_inc >= blk_n) begin
                            finished_next = 1'b1;
                            out_next = make_item(KIND_COMPLETE, idx_reg, '0, 1'b1,
                                                 acked_inc, dup_reg);
                        end else begin
                            if (bp_inc >= ack_batch_reg) begin
                                bp_next   = '0;
                                refill_go = !finished_reg;
                            end else begin
                                bp_next = bp_inc;
                            end
                            out_next = make_item(KIND_NEW_ACK, idx_reg, '0, !refill_go,
                                                 acked_inc, dup_reg);
                            if (refill_go) begin
                                want_next    = (refill_burst_reg == '0) ? BURST_W'(1)
                                                                        : refill_burst_reg;
                                made_next    = '0;
                                cand_next    = step_idx(ptr_reg, blk_n);
                                steps_next   = '0;
                                chk_vld_next = 1'b0;
                                state_next   = ST_SCAN;
                            end
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (chk_vld_reg && !mem_q_reg) begin
                    pick_next  = chk_reg;
                    ptr_next   = chk_reg;
                    state_next = ST_EMIT;
                end else if (steps_reg >= blk_n) begin
                    chk_vld_next = 1'b0;
                    if (!chk_vld_reg) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    mem_re       = 1'b1;
                    mem_raddr    = cand_reg;
                    chk_next     = cand_reg;
                    chk_vld_next = 1'b1;
                    cand_next    = step_idx(cand_reg, blk_n);
                    steps_next   = steps_reg + CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_next     = make_item(KIND_SEND, pick_reg,
                                             ({1'b0, pick_reg} == blk_n - CNT_W'(1))
                                                 ? last_bytes_reg : FULL_BYTES,
                                             last_pick, acked_reg, dup_reg);
                    m_valid_next = 1'b1;
                    made_next    = BURST_W'(made_reg + BURST_W'(1));
                    if (last_pick) begin
                        state_next = ST_IDLE;
                    end else begin
                        cand_next    = step_idx(pick_reg, blk_n);
                        steps_next   = '0;
                        chk_vld_next = 1'b0;
                        state_next   = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            ptr_reg      <= '0;
            acked_reg    <= '0;
            dup_reg      <= '0;
            bp_reg       <= '0;
            finished_reg <= 1'b0;
            chk_vld_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            ptr_reg      <= ptr_next;
            acked_reg    <= acked_next;
            dup_reg      <= dup_next;
            bp_reg       <= bp_next;
            finished_reg <= finished_next;
            chk_vld_reg  <= chk_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        cand_reg  <= cand_next;
        chk_reg   <= chk_next;
        steps_reg <= steps_next;
        made_reg  <= made_next;
        want_reg  <= want_next;
        pick_reg  <= pick_next;
        out_reg   <= out_next;
    end

    assign s_ready = ready_c;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

/* rtl/srs_checker.sv */
module srs_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input srs_pkg::srs_out_t m_data
);
    import srs_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ack_no_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_SEND |-> m_data.block_bytes == '0)
        else $error("ack result carries a byte length");

    a_single_results: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_BAD_INDEX || m_data.kind == KIND_DUP_ACK ||
                    m_data.kind == KIND_COMPLETE) |-> m_data.last)
        else $error("single-result ack not marked last");

    a_dup_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_DUP_ACK |-> m_data.duplicate_count != '0)
        else $error("duplicate ack not counted");

endmodule

bind selective_resend_scheduler_core srs_checker u_srs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/srs_schedule_checker.sv */
module srs_schedule_checker #(
    parameter int unsigned BLOCK_BYTES = 60000
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  srs_pkg::srs_in_t               s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  srs_pkg::srs_out_t              m_data,
    output int unsigned                    fail_count,
    output int unsigned                    pending
);
    import srs_pkg::*;

    logic [CNT_W-1:0]   total_blocks_r;
    logic [BYTES_W-1:0] last_bytes_r;
    logic [BURST_W-1:0] start_burst_r;
    logic [BURST_W-1:0] refill_burst_r;
    logic [BATCH_W-1:0] ack_batch_r;

    bit                 acked_map [MAX_BLOCKS];
    logic [IDX_W-1:0]   scan_ptr;
    logic [CNT_W-1:0]   acked_total;
    logic [DUP_W-1:0]   dup_total;
    logic [BATCH_W-1:0] batch_prog;
    bit                 finished;

    srs_out_t due_beats [$];

    function automatic int unsigned live_blocks();
        if (total_blocks_r == 0) return 1;
        if (total_blocks_r > MAX_BLOCKS) return MAX_BLOCKS;
        return total_blocks_r;
    endfunction

    task automatic push_beat(input logic [2:0] kind, input logic [IDX_W-1:0] idx,
                             input logic [BYTES_W-1:0] bytes);
        srs_out_t b;
        b.kind            = kind;
        b.pick_index      = idx;
        b.block_bytes     = bytes;
        b.last            = 1'b0;
        b.acked_count     = acked_total;
        b.duplicate_count = dup_total;
        due_beats.push_back(b);
    endtask

    task automatic emit_burst(input logic [BURST_W-1:0] len);
        int unsigned n;
        int unsigned want;
        int unsigned made;
        int unsigned c;
        int unsigned step;
        bit          found;
        n    = live_blocks();
        want = (len == 0) ? 1 : len;
        made = 0;
        while (made < want) begin
            c     = scan_ptr;
            found = 1'b0;
            for (step = 0; step < n && !found; step++) begin
                c = c + 1;
                if (c >= n) c = 0;
                if (!acked_map[c]) found = 1'b1;
            end
            if (!found) break;
            scan_ptr = IDX_W'(c);
            push_beat(KIND_SEND, IDX_W'(c),
                      (c == n - 1) ? last_bytes_r : BYTES_W'(BLOCK_BYTES));
            made++;
        end
    endtask

    task automatic resolve_item(input srs_in_t item);
        int unsigned n;
        int unsigned first;
        srs_out_t    tail;
        n     = live_blocks();
        first = due_beats.size();
        if (item.operation == OP_START) begin
            if (!finished) emit_burst(start_burst_r);
        end else if (item.block_index >= n) begin
            push_beat(KIND_BAD_INDEX, item.block_index, '0);
        end else if (acked_map[item.block_index]) begin
            if (dup_total != '1) dup_total++;
            push_beat(KIND_DUP_ACK, item.block_index, '0);
        end else begin
            acked_map[item.block_index] = 1'b1;
            if (acked_total != '1) acked_total++;
            if (!finished && acked_total >= n) begin
                finished = 1'b1;
                push_beat(KIND_COMPLETE, item.block_index, '0);
            end else begin
                push_beat(KIND_NEW_ACK, item.block_index, '0);
                batch_prog++;
                if (batch_prog >= ack_batch_r) begin
                    batch_prog = '0;
                    if (!finished) emit_burst(refill_burst_r);
                end
            end
        end
        if (due_beats.size() > first) begin
            tail      = due_beats.pop_back();
            tail.last = 1'b1;
            due_beats.push_back(tail);
        end
    endtask

    always @(posedge aclk) begin
        srs_out_t want;
        if (!aresetn) begin
            total_blocks_r = 1;
            last_bytes_r   = '0;
            start_burst_r  = 63;
            refill_burst_r = 50;
            ack_batch_r    = 50;
            foreach (acked_map[i]) acked_map[i] = 1'b0;
            scan_ptr    = '0;
            acked_total = '0;
            dup_total   = '0;
            batch_prog  = '0;
            finished    = 1'b0;
            due_beats.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TOTAL_BLOCKS:     total_blocks_r = cfg_wdata[CNT_W-1:0];
                    REG_LAST_BLOCK_BYTES: last_bytes_r   = cfg_wdata[BYTES_W-1:0];
                    REG_START_BURST:      start_burst_r  = cfg_wdata[BURST_W-1:0];
                    REG_REFILL_BURST:     refill_burst_r = cfg_wdata[BURST_W-1:0];
                    REG_ACK_BATCH:        ack_batch_r    = cfg_wdata[BATCH_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) resolve_item(s_data);
            if (m_valid && m_ready) begin
                if (due_beats.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected beat: kind %0d idx %0d bytes %0d last %0b",
                                 m_data.kind, m_data.pick_index, m_data.block_bytes,
                                 m_data.last);
                    fail_count++;
                end else begin
                    want = due_beats.pop_front();
                    if (m_data.kind !== want.kind || m_data.pick_index !== want.pick_index ||
                        m_data.block_bytes !== want.block_bytes ||
                        m_data.last !== want.last ||
                        m_data.acked_count !== want.acked_count ||
                        m_data.duplicate_count !== want.duplicate_count) begin
                        if (fail_count < 10) begin
                            $display("beat mismatch, expected: kind %0d idx %0d bytes %0d",
                                     want.kind, want.pick_index, want.block_bytes);
                            $display("  last %0b acked %0d dup %0d", want.last,
                                     want.acked_count, want.duplicate_count);
                            $display("  actual: kind %0d idx %0d bytes %0d", m_data.kind,
                                     m_data.pick_index, m_data.block_bytes);
                            $display("  last %0b acked %0d dup %0d", m_data.last,
                                     m_data.acked_count, m_data.duplicate_count);
                        end
                        fail_count++;
                    end
                end
            end
        end
        pending <= due_beats.size();
    end

endmodule

/* tb/selective_resend_scheduler_core_tb.sv */
module selective_resend_scheduler_core_tb;
    import srs_pkg::*;

    localparam int unsigned     BLOCK_BYTES  = 60000;
    localparam int unsigned     DRAIN_CYCLES = MAX_BLOCKS + 64;
    localparam longint unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned     HOLD_AT      = 60;
    localparam int unsigned     HOLD_CYCLES  = 600;
    localparam int unsigned     RANDOM_PHASES = 8;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY_FIFTH} rx_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    srs_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    srs_out_t              m_data;

    int unsigned     fail_count;
    int unsigned     pending;
    longint unsigned cycles = 0;
    int unsigned     items_sent = 0;
    int unsigned     burst_left = 0;
    int unsigned     cur_blocks = 1;

    bit          confirmed [MAX_BLOCKS];
    int unsigned confirmed_count = 0;
    int unsigned confirmed_list [$];

    selective_resend_scheduler_core #(.BLOCK_BYTES(BLOCK_BYTES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    srs_schedule_checker #(.BLOCK_BYTES(BLOCK_BYTES)) u_check (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[selective_resend_scheduler_core] ERROR");
            $finish;
        end
    end

    initial begin : receiver
        rx_mode_t    mode;
        int unsigned left;
        int unsigned tick;
        bit          hold_done;
        mode      = RX_OPEN;
        left      = 0;
        tick      = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && items_sent >= HOLD_AT && s_valid) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 200);
            end
            left--;
            tick++;
            case (mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= (tick % 5 == 0);
            endcase
        end
    end

    function automatic srs_in_t start_beat();
        srs_in_t item;
        item.operation   = OP_START;
        item.block_index = IDX_W'($urandom);
        return item;
    endfunction

    function automatic srs_in_t ack_of(input int unsigned idx);
        srs_in_t item;
        item.operation   = OP_ACK;
        item.block_index = IDX_W'(idx);
        return item;
    endfunction

    function automatic int unsigned fresh_index();
        int unsigned base;
        int unsigned k;
        int unsigned idx;
        base = $urandom_range(0, cur_blocks - 1);
        for (k = 0; k < cur_blocks; k++) begin
            idx = (base + k) % cur_blocks;
            if (!confirmed[idx]) return idx;
        end
        return $urandom_range(0, MAX_BLOCKS - 1);
    endfunction

    // mostly acks of not-yet-acked blocks; keep the transfer from completing
    function automatic srs_in_t random_beat();
        srs_in_t     item;
        int unsigned r;
        int unsigned idx;
        r   = $urandom_range(0, 99);
        idx = $urandom_range(0, MAX_BLOCKS - 1);
        if (r < 58)
            idx = fresh_index();
        else if (r < 72 && confirmed_list.size() > 0)
            idx = confirmed_list[$urandom_range(0, confirmed_list.size() - 1)];
        else if (r < 80 && cur_blocks < MAX_BLOCKS)
            idx = $urandom_range(cur_blocks, MAX_BLOCKS - 1);
        item = (r >= 86) ? start_beat() : ack_of(idx);
        if (item.operation == OP_ACK && item.block_index < cur_blocks &&
            !confirmed[item.block_index] && confirmed_count + 1 >= cur_blocks)
            item = start_beat();
        return item;
    endfunction

    function automatic int unsigned random_burst();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 63;
            2:       return 1;
            default: return $urandom_range(1, 63);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                             input int unsigned width);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        if (width < CFG_DATA_W && $urandom_range(0, 1) == 1)
            data = data | (CFG_DATA_W'($urandom) << width);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic configure(input int unsigned blocks, input int unsigned lbytes,
                             input int unsigned sburst, input int unsigned rburst,
                             input int unsigned batch);
        write_reg(REG_TOTAL_BLOCKS, blocks, CNT_W);
        write_reg(REG_LAST_BLOCK_BYTES, lbytes, BYTES_W);
        write_reg(REG_START_BURST, sburst, BURST_W);
        write_reg(REG_REFILL_BURST, rburst, BURST_W);
        write_reg(REG_ACK_BATCH, batch, BATCH_W);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                      $urandom, CFG_DATA_W);
        cfg_wr_en <= 1'b0;
        cur_blocks = (blocks == 0) ? 1 : ((blocks > MAX_BLOCKS) ? MAX_BLOCKS : blocks);
    endtask

    task automatic offer(input srs_in_t item);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (item.operation == OP_ACK && item.block_index < cur_blocks &&
            !confirmed[item.block_index]) begin
            confirmed[item.block_index] = 1'b1;
            confirmed_count++;
            confirmed_list.push_back(item.block_index);
        end
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // drain all beats, then give a fruitless scan time to finish
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int unsigned ph;
        int unsigned k;
        int unsigned count;
        int unsigned blocks;
        int unsigned lbytes;
        int unsigned batch;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        configure(0, 0, 0, 63, 4095);
        offer(start_beat());
        offer(start_beat());
        offer(ack_of(1));
        offer(ack_of(MAX_BLOCKS - 1));
        settle();

        configure(8191, 59999, 63, 0, 0);
        offer(start_beat());
        offer(ack_of(0));
        offer(ack_of(0));
        offer(ack_of(MAX_BLOCKS - 1));
        offer(ack_of(1));
        offer(ack_of(2));
        offer(ack_of(3));
        settle();

        configure(4, 59999, 5, 7, 2);
        offer(start_beat());
        offer(ack_of(2));
        offer(ack_of(9));
        offer(ack_of(MAX_BLOCKS - 1));
        settle();

        configure(9, $urandom_range(1, 59998), 3, 2, 1);
        offer(start_beat());
        offer(ack_of(4));
        offer(start_beat());
        settle();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                2:       blocks = $urandom_range(MAX_BLOCKS + 1, 8191);
                5:       blocks = MAX_BLOCKS;
                default: blocks = confirmed_count + $urandom_range(6, 90);
            endcase
            case ($urandom_range(0, 4))
                0:       lbytes = 0;
                1:       lbytes = 59999;
                2:       lbytes = 16'hFFFF;
                default: lbytes = $urandom_range(0, 59999);
            endcase
            case ($urandom_range(0, 5))
                0:       batch = 0;
                1:       batch = 1;
                2:       batch = 4095;
                3:       batch = $urandom_range(0, 4095);
                default: batch = $urandom_range(2, 10);
            endcase
            configure(blocks, lbytes, random_burst(), random_burst(), batch);
            count = $urandom_range(28, 42);
            for (k = 0; k < count; k++) offer(random_beat());
            settle();
        end

        configure(confirmed_count + 3, $urandom_range(0, 59999), $urandom_range(1, 63),
                  $urandom_range(1, 63), 1);
        offer(start_beat());
        while (confirmed_count < cur_blocks) offer(ack_of(fresh_index()));
        offer(start_beat());
        offer(ack_of(confirmed_list[0]));
        offer(ack_of(MAX_BLOCKS - 1));
        settle();

        configure(confirmed_count + 20, 59999, 63, 63, 0);
        offer(start_beat());
        offer(ack_of(fresh_index()));
        offer(ack_of(fresh_index()));
        offer(start_beat());
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("[selective_resend_scheduler_core] OK");
        end else begin
            $display("[selective_resend_scheduler_core] ERROR");
        end
        $finish;
    end

endmodule
